@@ rtl/bed_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, constants and tables for the band energy denormalizer.
// ----------------------------------------------------------------------------
package bed_pkg;

    // Number of bands in the edge table, default for the top-level parameter.
    localparam int NUM_BANDS_DEF  = 21;
    // Entries of the fractional power-of-two table.
    localparam int EXP_TABLE_SIZE = 64;
    localparam int EXP_AW         = (EXP_TABLE_SIZE > 1) ? $clog2(EXP_TABLE_SIZE) : 1;
    // Largest frame length selector that takes effect.
    localparam int MAX_SHIFT      = 3;

    // Item kinds carried in tuser.
    localparam logic KIND_ENERGY = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_BAND = 2'd0;
    localparam logic [1:0] CFG_END_BAND   = 2'd1;
    localparam logic [1:0] CFG_SHIFT      = 2'd2;

    // Band edges in units of 2^shift bins.
    localparam logic [9:0] BAND_EDGES [22] = '{
        10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8, 10'd10,
        10'd12, 10'd14, 10'd16, 10'd20, 10'd24, 10'd28, 10'd34, 10'd40, 10'd48,
        10'd60, 10'd78, 10'd100};

    // Mean log2 energy of each band, Q10.
    localparam logic [12:0] MEAN_Q10 [21] = '{
        13'd6592, 13'd6400, 13'd5888, 13'd5440, 13'd5184, 13'd4928, 13'd4608,
        13'd4480, 13'd4992, 13'd4800, 13'd4672, 13'd4544, 13'd4992, 13'd4736,
        13'd4416, 13'd4608, 13'd4480, 13'd4736, 13'd4864, 13'd4544, 13'd3840};

    // Mantissa of 2^(t/1024) in Q30.
    typedef logic [30:0] t_mant;
    typedef t_mant t_exp_tab [EXP_TABLE_SIZE];

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAND,
        ST_EXPO,
        ST_MULT,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_energy;
        logic take_coef;
        logic find_band;
        logic calc_expo;
        logic mult;
        logic round;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

    // Integer square root, one result bit per step; used at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = x;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Builds the mantissa table from products of the roots 2^(2^-m).
    function automatic t_exp_tab build_exp_tab();
        logic [63:0] roots [11];
        t_exp_tab    tab;
        logic [63:0] v;
        logic [9:0]  t;
        roots[0] = 64'd1 << 31;
        roots[1] = isqrt64(64'd1 << 61);
        for (int m = 2; m <= 10; m++) begin
            roots[m] = isqrt64(roots[m-1] << 30);
        end
        for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
            t = 10'((k * 1024) / EXP_TABLE_SIZE);
            v = 64'd1 << 30;
            for (int j = 0; j < 10; j++) begin
                if (t[j]) begin
                    v = (v * roots[10-j] + (64'd1 << 29)) >> 30;
                end
            end
            tab[k] = v[30:0];
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bed_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bed_ctrl
// Controller: accepts input words and steps each coefficient through the
// datapath stages, then hands it to the output register.
// ----------------------------------------------------------------------------
module bed_ctrl
    import bed_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    input  wire logic       i_s_axis_tuser,
    output logic            o_s_axis_tready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser == KIND_COEF) begin
                        o_cmd.take_coef = 1'b1;
                        n_state         = ST_BAND;
                    end else begin
                        o_cmd.write_energy = 1'b1;
                    end
                end
            end
            ST_BAND: begin
                o_cmd.find_band = 1'b1;
                n_state         = ST_EXPO;
            end
            ST_EXPO: begin
                o_cmd.calc_expo = 1'b1;
                n_state         = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register is free.
                if (!i_status.out_blocked) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A coefficient word always starts the band search next.
    a_coef_to_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == KIND_COEF)
        |=> r_state == ST_BAND)
        else $error("coefficient did not start the band search");

    // Commands never overlap.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("overlapping datapath commands");

    // After a result is loaded the controller is free for the next word.
    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_s_axis_tready)
        else $error("not ready after result load");

endmodule
`default_nettype wire

@@ rtl/bed_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bed_datapath
// Datapath: configuration, energy store, bin and band tracking, exponent,
// mantissa multiply, rounding shift and the output register.
// ----------------------------------------------------------------------------
module bed_datapath
    import bed_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic [4:0]  i_band,
    input  wire logic [15:0] i_log_energy,
    input  wire logic [15:0] i_coefficient,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [48:0]      o_frequency_value,
    output logic [9:0]       o_bin_index,
    output logic             o_last_of_frame
);

    localparam int          BAND_AW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [9:0]  BIN_LIMIT = 10'(BAND_EDGES[NUM_BANDS] << MAX_SHIFT);
    localparam logic [4:0]  BANDS_5   = 5'(NUM_BANDS);
    localparam t_exp_tab    EXP_TAB   = build_exp_tab();

    // Configuration registers.
    logic [4:0] r_start_band;
    logic [4:0] r_end_band;
    logic [1:0] r_shift_cfg;

    // Energy store, one entry per band, sized to a power of two.
    logic [15:0] r_energy [2**BAND_AW];

    // Bin tracking and per-item working registers.
    logic [9:0]        r_bin_cnt;
    logic [9:0]        r_bin;
    logic              r_last;
    logic [15:0]       r_mag;
    logic              r_neg;
    logic [4:0]        r_band;
    logic              r_in_range;
    logic [EXP_AW-1:0] r_k;
    logic signed [6:0] r_sh;
    logic [46:0]       r_prod;
    logic [48:0]       r_rmag;

    // Output register.
    logic        r_out_valid;
    logic [48:0] r_out_value;
    logic [9:0]  r_out_bin;
    logic        r_out_last;

    logic [1:0]  w_shift;
    logic [9:0]  w_total;
    logic [9:0]  w_bin_start;
    logic [9:0]  w_bin_next;
    logic        w_last;
    logic [4:0]  w_band;
    logic [4:0]  w_end_eff;
    logic signed [17:0] w_lg_raw;
    logic signed [17:0] w_lg;
    logic signed [7:0]  w_ip;
    logic [9:0]  w_frac;
    logic [EXP_AW+10:0] w_kprod;
    logic [1:0]  w_lshamt;
    logic [5:0]  w_rshamt;
    logic [63:0] w_rsum;

    // Frame geometry from the shift selector.
    assign w_shift = (r_shift_cfg > 2'(MAX_SHIFT)) ? 2'(MAX_SHIFT) : r_shift_cfg;
    assign w_total = BAND_EDGES[NUM_BANDS] << w_shift;

    // Frame restarts when the counter is at or past the frame length.
    assign w_bin_start = (r_bin_cnt >= w_total) ? 10'd0 : r_bin_cnt;
    assign w_bin_next  = w_bin_start + 10'd1;
    assign w_last      = (w_bin_next >= w_total);

    // Band of the current bin: the last edge at or below it.
    always_comb begin
        w_band = '0;
        for (int i = 1; i < NUM_BANDS; i++) begin
            if ((BAND_EDGES[i] << w_shift) <= r_bin) begin
                w_band = 5'(i);
            end
        end
    end

    // Exponent: energy plus band mean, clamped at 32.0.
    assign w_end_eff = (r_end_band > BANDS_5) ? BANDS_5 : r_end_band;
    assign w_lg_raw  = signed'({{2{r_energy[r_band[BAND_AW-1:0]][15]}},
                                r_energy[r_band[BAND_AW-1:0]]})
                     + signed'({5'd0, MEAN_Q10[r_band]});
    assign w_lg      = (w_lg_raw > 18'sd32768) ? 18'sd32768 : w_lg_raw;
    assign w_ip      = w_lg[17:10];
    assign w_frac    = w_lg[9:0];
    assign w_kprod   = (EXP_AW+11)'(w_frac) * (EXP_AW+11)'(EXP_TABLE_SIZE);

    // Rounding shift amounts; a non-positive shift count is a left shift.
    assign w_lshamt = 2'(-r_sh);
    assign w_rshamt = r_sh[5:0];
    assign w_rsum   = 64'(r_prod) + (64'd1 << (w_rshamt - 6'd1));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_band <= 5'd0;
            r_end_band   <= 5'd21;
            r_shift_cfg  <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_BAND: r_start_band <= i_cfg_data;
                CFG_END_BAND:   r_end_band   <= i_cfg_data;
                CFG_SHIFT:      r_shift_cfg  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Energy store writes; bands at or above NUM_BANDS are dropped.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_energy && (i_band < BANDS_5)) begin
            r_energy[i_band[BAND_AW-1:0]] <= i_log_energy;
        end
    end

    // Bin and band counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
            r_band    <= '0;
        end else begin
            if (i_cmd.take_coef) begin
                r_bin_cnt <= w_last ? 10'd0 : w_bin_next;
            end
            if (i_cmd.find_band) begin
                r_band <= w_band;
            end
        end
    end

    // Working registers of the coefficient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_coef) begin
            r_bin  <= w_bin_start;
            r_last <= w_last;
            r_neg  <= i_coefficient[15];
            r_mag  <= i_coefficient[15] ? 16'(~i_coefficient + 16'd1) : i_coefficient;
        end
        if (i_cmd.calc_expo) begin
            r_in_range <= (r_band >= r_start_band) && (r_band < w_end_eff);
            r_k        <= w_kprod[EXP_AW+9:10];
            r_sh       <= 7'sd29 - w_ip[6:0];
        end
        if (i_cmd.mult) begin
            r_prod <= 47'(r_mag) * 47'(EXP_TAB[r_k]);
        end
        if (i_cmd.round) begin
            if (r_sh <= 7'sd0) begin
                r_rmag <= 49'(r_prod) << w_lshamt;
            end else begin
                r_rmag <= 49'(w_rsum >> w_rshamt);
            end
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (!r_in_range) begin
                r_out_value <= '0;
            end else begin
                r_out_value <= r_neg ? 49'(~r_rmag + 49'd1) : r_rmag;
            end
            r_out_bin  <= r_bin;
            r_out_last <= r_last;
        end
    end

    assign o_status.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_frequency_value    = r_out_value;
    assign o_bin_index          = r_out_bin;
    assign o_last_of_frame      = r_out_last;

    // The bin counter never leaves the longest frame.
    a_bin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_cnt < BIN_LIMIT)
        else $error("bin counter beyond frame length");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_out_ready))
        else $error("output word overwritten");

    // Bins outside the decoded bands give zero.
    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && !r_in_range) |=> r_out_value == '0)
        else $error("nonzero value outside decoded bands");

endmodule
`default_nettype wire

@@ rtl/band_energy_denormalizer_core.sv @@
`default_nettype none
// Each coefficient word is stepped through the controller's six-state walk (accept,
// band search, exponent, multiply, rounding shift, output load); the output load waits
// while the output register still holds an untaken word, and no new word is accepted
// until the walk is done. Energy words are accepted while idle and give no result.
// Reset (synchronous, active low) clears the counters and the output valid flag and
// loads the configuration defaults; the energy store holds no defined value until written.
// ----------------------------------------------------------------------------
// band_energy_denormalizer_core
// Rescales normalized spectral coefficients by their band's stored energy.
// ----------------------------------------------------------------------------
module band_energy_denormalizer_core
    import bed_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // band[4:0], log_energy[20:5],
                                              // coefficient[36:21], zero fill
    input  wire logic        i_s_axis_tuser,  // kind[0]
    // Output stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,  // frequency_value[48:0],
                                              // bin_index[58:49], zero fill
    output logic             o_m_axis_tlast   // last_of_frame
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [48:0] w_value;
    logic [9:0]  w_bin;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    bed_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    bed_datapath #(
        .NUM_BANDS (NUM_BANDS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_band            (i_s_axis_tdata[4:0]),
        .i_log_energy      (i_s_axis_tdata[20:5]),
        .i_coefficient     (i_s_axis_tdata[36:21]),
        .o_out_valid       (o_m_axis_tvalid),
        .i_out_ready       (i_m_axis_tready),
        .o_frequency_value (w_value),
        .o_bin_index       (w_bin),
        .o_last_of_frame   (o_m_axis_tlast)
    );

    // Pack the result word.
    assign o_m_axis_tdata = {5'd0, w_bin, w_value};

endmodule
`default_nettype wire
